// ----- design/ttml_pkg.sv -----
`timescale 1ns / 1ps

package ttml_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int GROUP_SAMPLES = 5;

    localparam int CODE_W = 12;
    localparam int TEMP_W = 12;
    localparam int IDX_W  = 6;
    localparam int PTS_W  = 7;
    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = CODE_W + TEMP_W;

    // sample group bookkeeping
    localparam int CNT_W   = $clog2(GROUP_SAMPLES);
    localparam int SUM_W   = CODE_W + $clog2(GROUP_SAMPLES);
    localparam int AVG_DIV = GROUP_SAMPLES - 2;
    localparam int TSUM_W  = $clog2(AVG_DIV * (2 ** CODE_W - 1) + 1);

    // floor(x / AVG_DIV) as (x * RECIP) >> RECIP_SH, exact for x below 2**TSUM_W
    localparam int RECIP_SH = TSUM_W + $clog2(AVG_DIV);
    localparam int RECIP    = (2 ** RECIP_SH + AVG_DIV - 1) / AVG_DIV;
    localparam int PROD_W   = TSUM_W + RECIP_SH + 1;

    // interpolation divide, two quotient bits per cycle
    localparam int MAG_W     = 2 * CODE_W;
    localparam int DIV_ITERS = MAG_W / 2;
    localparam int IT_W      = $clog2(DIV_ITERS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic REG_POINTS_IN_USE = 1'b0;

    typedef struct packed {
        logic                      is_lin;
        logic [IDX_W-1:0]          idx;
        logic [CODE_W-1:0]         code;
        logic signed [TEMP_W-1:0]  temp;
        logic [TSUM_W-1:0]         tsum;
    } t_job;

    typedef logic signed [TBL_AW+1:0] t_sidx;

endpackage

// ----- design/ttml_ram.sv -----
`timescale 1ns / 1ps

module ttml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ttml_queue.sv -----
`timescale 1ns / 1ps

module ttml_queue import ttml_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_head, n_head;
    logic [QA_W-1:0] r_tail, n_tail;
    logic [QA_W:0]   r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head = (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    assign o_job   = r_mem[r_head];
    assign o_full  = (r_count == (QA_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ----- design/ttml_front.sv -----
`timescale 1ns / 1ps

module ttml_front import ttml_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_kind,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [CODE_W-1:0]        i_code,
    input  logic signed [TEMP_W-1:0] i_temp,
    input  logic [CODE_W-1:0]        i_sample,
    input  logic                     i_full,
    output logic                     o_push,
    output t_job                     o_job
);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CODE_W-1:0] r_max, n_max;
    logic [CODE_W-1:0] r_min, n_min;
    logic [SUM_W-1:0]  acc_sum;
    logic [CODE_W-1:0] acc_max;
    logic [CODE_W-1:0] acc_min;
    logic              accept;
    logic              last_of_group;

    assign accept        = i_valid && !i_full;
    assign last_of_group = (r_cnt == CNT_W'(GROUP_SAMPLES - 1));

    // sample folded into the running group
    assign acc_sum = r_sum + SUM_W'(i_sample);
    assign acc_max = (i_sample > r_max) ? i_sample : r_max;
    assign acc_min = (i_sample < r_min) ? i_sample : r_min;

    always_comb begin
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_max  = r_max;
        n_min  = r_min;
        o_push = 1'b0;
        if (accept) begin
            if (i_kind == KIND_POINT) begin
                o_push = 1'b1;
            end else if (last_of_group) begin
                o_push = 1'b1;
                n_cnt  = '0;
                n_sum  = '0;
                n_max  = '0;
                n_min  = '1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                n_sum = acc_sum;
                n_max = acc_max;
                n_min = acc_min;
            end
        end
    end

    always_comb begin
        o_job.is_lin = (i_kind == KIND_SAMPLE);
        o_job.idx    = i_index;
        o_job.code   = i_code;
        o_job.temp   = i_temp;
        o_job.tsum   = TSUM_W'(acc_sum - SUM_W'(acc_max) - SUM_W'(acc_min));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_max <= '0;
            r_min <= '1;
        end else begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
            r_max <= n_max;
            r_min <= n_min;
        end
    end

    assign o_ready = !i_full;

endmodule

// ----- design/ttml_back.sv -----
`timescale 1ns / 1ps

module ttml_back import ttml_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TBL_AW-1:0] i_last,
    input  t_job              i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TEMP_W-1:0] o_temp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AVG  = 4'd1;
    localparam logic [3:0] S_RD0  = 4'd2;
    localparam logic [3:0] S_CHK0 = 4'd3;
    localparam logic [3:0] S_CHKL = 4'd4;
    localparam logic [3:0] S_MID  = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_GLO  = 4'd7;
    localparam logic [3:0] S_GHI  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [TSUM_W-1:0] r_tsum, n_tsum;
    logic [CODE_W-1:0] r_avg, n_avg;
    t_sidx             r_lo, n_lo;
    t_sidx             r_hi, n_hi;
    logic [TBL_AW-1:0] r_mid, n_mid;
    logic [CODE_W-1:0] r_clo, n_clo;
    logic [TEMP_W-1:0] r_tlo, n_tlo;
    logic [TEMP_W-1:0] r_thi, n_thi;
    logic [CODE_W-1:0] r_den, n_den;
    logic [TEMP_W-1:0] r_dtmag, n_dtmag;
    logic [CODE_W-1:0] r_dx, n_dx;
    logic              r_neg, n_neg;
    logic [CODE_W:0]   r_rem, n_rem;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [IT_W-1:0]   r_it, n_it;
    logic [TEMP_W-1:0] r_res, n_res;
    logic              r_ovalid, n_ovalid;
    logic [TEMP_W-1:0] r_odata, n_odata;

    logic                ram_we;
    logic [TBL_AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [CODE_W-1:0]   rd_code;
    logic [TEMP_W-1:0]   rd_temp;
    logic [PROD_W-1:0]   avg_prod;
    t_sidx               lohi_sum;
    logic [CODE_W:0]     den_w;
    logic [TEMP_W:0]     dt_w;
    logic [CODE_W:0]     div_rem;
    logic [MAG_W-1:0]    div_quo;
    logic [TEMP_W-1:0]   q_lo;

    ttml_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (TBL_AW'(i_job.idx)),
        .i_wdata ({i_job.code, i_job.temp}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_code  = ram_rdata[ENTRY_W-1:TEMP_W];
    assign rd_temp  = ram_rdata[TEMP_W-1:0];
    assign avg_prod = PROD_W'(r_tsum) * PROD_W'(RECIP);
    assign lohi_sum = r_lo + r_hi;
    assign den_w    = {1'b0, r_clo} - {1'b0, rd_code};
    assign dt_w     = {r_tlo[TEMP_W-1], r_tlo} - {rd_temp[TEMP_W-1], rd_temp};
    assign q_lo     = r_quo[TEMP_W-1:0];

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign ram_we = o_pop && !i_job.is_lin && (int'(i_job.idx) < TABLE_DEPTH);

    // table read address, read data is registered in the memory
    always_comb begin
        unique case (r_state)
            S_CHK0:  ram_raddr = i_last;
            S_MID:   ram_raddr = (r_lo <= r_hi) ? lohi_sum[TBL_AW:1] : r_lo[TBL_AW-1:0];
            S_GLO:   ram_raddr = r_hi[TBL_AW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    // two restoring divide steps
    always_comb begin
        div_rem = r_rem;
        div_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            div_rem = {div_rem[CODE_W-1:0], div_quo[MAG_W-1]};
            div_quo = {div_quo[MAG_W-2:0], 1'b0};
            if (div_rem >= {1'b0, r_den}) begin
                div_rem    = div_rem - {1'b0, r_den};
                div_quo[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_tsum   = r_tsum;
        n_avg    = r_avg;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_clo    = r_clo;
        n_tlo    = r_tlo;
        n_thi    = r_thi;
        n_den    = r_den;
        n_dtmag  = r_dtmag;
        n_dx     = r_dx;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_it     = r_it;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && i_job.is_lin) begin
                    n_tsum  = i_job.tsum;
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                n_avg   = avg_prod[RECIP_SH +: CODE_W];
                n_state = S_RD0;
            end
            S_RD0: begin
                n_state = S_CHK0;
            end
            S_CHK0: begin
                if (r_avg <= rd_code) begin
                    n_res   = rd_temp;
                    n_state = S_OUT;
                end else begin
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                if (r_avg >= rd_code) begin
                    n_res   = rd_temp;
                    n_state = S_OUT;
                end else begin
                    n_lo    = '0;
                    n_hi    = $signed({2'b00, i_last});
                    n_state = S_MID;
                end
            end
            S_MID: begin
                if (r_lo <= r_hi) begin
                    n_mid   = lohi_sum[TBL_AW:1];
                    n_state = S_CMP;
                end else begin
                    n_state = S_GLO;
                end
            end
            S_CMP: begin
                if (rd_code > r_avg) begin
                    n_hi    = $signed({2'b00, r_mid}) - t_sidx'(1);
                    n_state = S_MID;
                end else if (rd_code < r_avg) begin
                    n_lo    = $signed({2'b00, r_mid}) + t_sidx'(1);
                    n_state = S_MID;
                end else begin
                    n_res   = rd_temp;
                    n_state = S_OUT;
                end
            end
            S_GLO: begin
                n_clo   = rd_code;
                n_tlo   = rd_temp;
                n_state = S_GHI;
            end
            S_GHI: begin
                n_thi = rd_temp;
                if (den_w[CODE_W] || (den_w == '0)) begin
                    n_res   = rd_temp;
                    n_state = S_OUT;
                end else begin
                    n_den   = den_w[CODE_W-1:0];
                    n_neg   = dt_w[TEMP_W];
                    n_dtmag = dt_w[TEMP_W] ? TEMP_W'(-dt_w) : dt_w[TEMP_W-1:0];
                    n_dx    = r_avg - rd_code;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_quo   = MAG_W'(r_dtmag) * MAG_W'(r_dx);
                n_rem   = '0;
                n_it    = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_rem;
                n_quo = div_quo;
                n_it  = r_it + 1'b1;
                if (r_it == IT_W'(DIV_ITERS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res   = r_thi + (r_neg ? (~q_lo + 1'b1) : q_lo);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsum  <= n_tsum;
        r_avg   <= n_avg;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_clo   <= n_clo;
        r_tlo   <= n_tlo;
        r_thi   <= n_thi;
        r_den   <= n_den;
        r_dtmag <= n_dtmag;
        r_dx    <= n_dx;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_it    <= n_it;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_temp  = r_odata;

endmodule

// ----- design/thermistor_trimmed_mean_linearizer.sv -----
`timescale 1ns / 1ps
// lookup path: with the back end idle a group's result passes through the averaging and the check
//   against the first and the last table point, then, where needed, the search and the divide
// throughput: one input per cycle while the 4-entry queue has room; the back end takes a table
//   write as it pops it and works on one group of five samples at a time (search and divide)
// reset: synchronous, active low; clears the sample group, queue, sequencer and output
//   valid and sets points_in_use to 1; the table is undefined until written, no clear pass
module thermistor_trimmed_mean_linearizer import ttml_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] point_index, [17:6] point_code, [29:18] point_temp, [41:30] sample, rest zero
    input  logic [47:0] s_axis_tdata,
    // [0] kind
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] temperature, rest zero
    output logic [15:0] m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [PTS_W-1:0]  r_points;
    logic [TBL_AW-1:0] last_idx;
    logic              reg_wr;

    t_job              push_job;
    t_job              head_job;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              bk_busy;
    logic [TEMP_W-1:0] out_temp;

    // register port, word index taken from paddr[2]
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_POINTS_IN_USE);
    assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? 32'(r_points) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= PTS_W'(1);
        end else if (reg_wr) begin
            r_points <= pwdata[PTS_W-1:0];
        end
    end

    // last table slot in use: zero points acts as one, too many clamps to the table
    always_comb begin
        priority if (r_points == '0) begin
            last_idx = '0;
        end else if (int'(r_points) > TABLE_DEPTH) begin
            last_idx = TBL_AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = TBL_AW'(r_points - 1'b1);
        end
    end

    // front end: table writes pass straight to the queue, samples build up a group
    ttml_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_kind   (s_axis_tuser),
        .i_index  (s_axis_tdata[5:0]),
        .i_code   (s_axis_tdata[17:6]),
        .i_temp   (s_axis_tdata[29:18]),
        .i_sample (s_axis_tdata[41:30]),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    // keeps table writes and lookups in arrival order
    ttml_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: table memory, search, interpolation and output register
    ttml_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_last  (last_idx),
        .i_job   (head_job),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_busy  (bk_busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_temp  (out_temp)
    );

    assign m_axis_tdata = {4'b0000, out_temp};

    // no push into a full queue
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // no pop from an empty queue
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // a popped lookup starts the sequencer
    a_lookup_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && head_job.is_lin) |=> bk_busy)
        else $error("lookup popped but back end idle");

    // the sequencer only takes work while idle
    a_pop_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !bk_busy)
        else $error("queue popped while back end busy");

endmodule

// ----- sim/thermistor_trimmed_mean_linearizer_test.sv -----
`timescale 1ns / 1ps

module thermistor_trimmed_mean_linearizer_test;
    import ttml_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int IDLE_PCT       = 29;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PASS = 32;
    localparam int CODE_MAX       = 2 ** CODE_W - 1;

    // register byte addresses, 4 bytes per register
    localparam logic [2:0] ADDR_POINTS_IN_USE = {REG_POINTS_IN_USE, 2'b00};
    localparam logic [2:0] ADDR_SPARE         = {~REG_POINTS_IN_USE, 2'b00};

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [TEMP_W-1:0] temp;
        logic [CODE_W-1:0] sample;
    } t_sensor_request;

    // table, sample group and register mirror; predicts one temperature per full group
    class t_trimmed_mean_tracker;
        logic [CODE_W-1:0]        code_tab [TABLE_DEPTH];
        logic signed [TEMP_W-1:0] temp_tab [TABLE_DEPTH];
        logic [PTS_W-1:0]         points_in_use = 7'd1;
        int                       samples_taken = 0;
        int                       running_sum = 0;
        int                       running_max = 0;
        int                       running_min = CODE_MAX;
        logic [TEMP_W-1:0]        expected_temps [$];
        int                       fails = 0;

        function void flag(string what);
            fails++;
            if (fails <= 10)
                $display("mismatch: %s", what);
        endfunction

        function int active_points();
            if (points_in_use < 1)
                return 1;
            if (points_in_use > TABLE_DEPTH)
                return TABLE_DEPTH;
            return int'(points_in_use);
        endfunction

        function void write_register(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_POINTS_IN_USE)
                points_in_use = value[PTS_W-1:0];
        endfunction

        function logic [TEMP_W-1:0] linearize(int avg);
            int lo;
            int hi;
            int mid;
            int num;
            int den;
            int t;
            lo = 0;
            hi = active_points() - 1;
            if (avg <= int'(code_tab[0]))
                return temp_tab[0];
            if (avg >= int'(code_tab[hi]))
                return temp_tab[hi];
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (int'(code_tab[mid]) > avg)
                    hi = mid - 1;
                else if (int'(code_tab[mid]) < avg)
                    lo = mid + 1;
                else
                    return temp_tab[mid];
            end
            // bracketing pair, interpolation truncates toward zero
            den = int'(code_tab[lo]) - int'(code_tab[hi]);
            if (den <= 0)
                return temp_tab[hi];
            num = (int'(temp_tab[lo]) - int'(temp_tab[hi])) * (avg - int'(code_tab[hi]));
            t = int'(temp_tab[hi]) + num / den;
            return t[TEMP_W-1:0];
        endfunction

        function void take_request(t_sensor_request r);
            int s;
            int avg;
            if (r.kind == KIND_POINT) begin
                code_tab[r.idx] = r.code;
                temp_tab[r.idx] = r.temp;
                return;
            end
            s = int'(r.sample);
            running_sum += s;
            if (s > running_max)
                running_max = s;
            if (s < running_min)
                running_min = s;
            samples_taken++;
            if (samples_taken < GROUP_SAMPLES)
                return;
            avg = (running_sum - running_max - running_min) / AVG_DIV;
            samples_taken = 0;
            running_sum = 0;
            running_max = 0;
            running_min = CODE_MAX;
            expected_temps.push_back(linearize(avg));
        endfunction

        function void match_temperature(logic [15:0] word);
            logic [TEMP_W-1:0] want;
            if (expected_temps.size() == 0) begin
                flag($sformatf("temperature %0d with none expected",
                               $signed(word[TEMP_W-1:0])));
                return;
            end
            want = expected_temps.pop_front();
            if (word[TEMP_W-1:0] !== want)
                flag($sformatf("temperature expected %0d got %0d",
                               $signed(want), $signed(word[TEMP_W-1:0])));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [5:0] point_index, [17:6] point_code, [29:18] point_temp, [41:30] sample, rest zero
    logic [47:0] s_axis_tdata = '0;
    // [0] kind
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [11:0] temperature, rest zero
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_trimmed_mean_tracker tracker;
    t_sensor_request       pending [$];
    t_sensor_request       offered;
    int                    pushed_count = 0;
    int                    accepted_count = 0;
    int                    cycle_count = 0;
    bit                    steady = 1'b0;
    bit                    hold_req = 1'b0;

    thermistor_trimmed_mean_linearizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // request sender: one nonblocking update of tvalid per edge, random gaps between requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                tracker.take_request(offered);
                accepted_count++;
            end
            if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                offered = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= offered.kind;
                s_axis_tdata  <= {6'd0, offered.sample, offered.temp, offered.code,
                                  offered.idx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off on request from the main flow
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_temperature(m_axis_tdata);
    end

    function automatic int rand_temp();
        int t;
        t = int'($urandom_range(0, 4000));
        return t - 2000;
    endfunction

    function automatic void push_request(t_sensor_request r);
        pending.push_back(r);
        pushed_count++;
    endfunction

    // point writes carry a random sample field, samples carry random point fields
    function automatic void push_point(int slot, int code, int temp);
        t_sensor_request r;
        r.kind   = KIND_POINT;
        r.idx    = slot[IDX_W-1:0];
        r.code   = code[CODE_W-1:0];
        r.temp   = temp[TEMP_W-1:0];
        r.sample = CODE_W'($urandom_range(0, CODE_MAX));
        push_request(r);
    endfunction

    function automatic void push_sample(int value);
        t_sensor_request r;
        r.kind   = KIND_SAMPLE;
        r.idx    = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        r.code   = CODE_W'($urandom_range(0, CODE_MAX));
        r.temp   = TEMP_W'(rand_temp());
        r.sample = value[CODE_W-1:0];
        push_request(r);
    endfunction

    function automatic void push_group(int center, int spread, bit outliers);
        for (int i = 0; i < GROUP_SAMPLES; i++) begin
            int v;
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > CODE_MAX)
                v = CODE_MAX;
            // one low and one high outlier, both trimmed away
            if (outliers && i == 0)
                v = 0;
            if (outliers && i == GROUP_SAMPLES - 1)
                v = CODE_MAX;
            push_sample(v);
        end
    endfunction

    // a group aimed at the table: exact hit, between two points, near a point, or anywhere
    function automatic void push_target_group();
        int n;
        int k;
        int lo_code;
        int hi_code;
        int pick;
        n = tracker.active_points();
        k = $urandom_range(0, n - 1);
        lo_code = int'(tracker.code_tab[k]);
        hi_code = (k + 1 < n) ? int'(tracker.code_tab[k + 1]) : CODE_MAX;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            push_group(lo_code, 0, $urandom_range(0, 3) == 0);
        else if (pick < 70 && hi_code > lo_code)
            push_group(lo_code + int'($urandom_range(0, hi_code - lo_code)), 0,
                       $urandom_range(0, 3) == 0);
        else if (pick < 85)
            push_group(lo_code, 40, 1'b0);
        else
            push_group(2048, 2048, 1'b0);
    endfunction

    task automatic wait_taken();
        while (accepted_count != pushed_count)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (accepted_count != pushed_count || tracker.expected_temps.size() != 0)
            @(posedge i_clk);
    endtask

    // drained, then let trailing table writes retire before touching the register
    task automatic wait_quiet();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ascending codes with random temperatures, duplicates now and then
    task automatic fill_table(int count);
        int code_now;
        int step;
        code_now = $urandom_range(0, 200);
        step = 3800 / count;
        for (int k = 0; k < count; k++) begin
            push_point(k, code_now, rand_temp());
            code_now += $urandom_range(0, step);
            if (code_now > CODE_MAX)
                code_now = CODE_MAX;
        end
        wait_taken();
    endtask

    // setup cycle then access cycle
    task automatic apb_access(input logic [2:0] addr, input logic write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (write)
            tracker.write_register(addr, wdata);
    endtask

    task automatic check_points_register();
        logic [31:0] value;
        apb_access(ADDR_POINTS_IN_USE, 1'b0, '0, value);
        if (value[PTS_W-1:0] !== tracker.points_in_use)
            tracker.flag($sformatf("points_in_use read expected %0d got %0d",
                                   tracker.points_in_use, value[PTS_W-1:0]));
    endtask

    function automatic int phase_points(int phase);
        case (phase)
            0: return 64;
            1: return 2;
            2: return 127;
            3: return 0;
            4: return $urandom_range(3, 63);
            5: return 1;
            6: return 65;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    initial begin
        logic [31:0] rdata;
        int          items;
        int          pick;
        tracker = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_points_register();

        // single-point table: endpoints, a far slot, a point write in the middle of a group
        push_point(0, 1000, -2000);
        push_point(TABLE_DEPTH - 1, CODE_MAX, 2000);
        push_group(0, 0, 1'b0);
        push_sample(CODE_MAX);
        push_sample(CODE_MAX);
        push_point(0, 1000, 2000);
        push_sample(CODE_MAX);
        push_sample(CODE_MAX);
        push_sample(CODE_MAX);

        for (int phase = 0; phase < PHASES; phase++) begin
            steady = 1'b0;
            wait_quiet();
            apb_access(ADDR_POINTS_IN_USE, 1'b1, phase_points(phase), rdata);
            check_points_register();
            if (phase == 4) begin
                // writes to an unused register address change nothing
                apb_access(ADDR_SPARE, 1'b1, $urandom, rdata);
                check_points_register();
            end
            if (phase < 2 || $urandom_range(0, 1) == 1)
                fill_table(tracker.active_points());
            if (phase == 0) begin
                // exact hit in the middle of the search, then between two neighbors
                push_group(int'(tracker.code_tab[31]), 0, 1'b0);
                push_group((int'(tracker.code_tab[10]) + int'(tracker.code_tab[11])) / 2,
                           0, 1'b1);
            end
            // long receiver hold-off while requests keep coming, fills the queue
            if (phase == 1)
                hold_req = 1'b1;
            // no idling on either side for this whole pass
            steady = (phase == 3);
            items = 0;
            while (items < ITEMS_PER_PASS) begin
                if (phase == 5 && items >= ITEMS_PER_PASS / 2 && items < ITEMS_PER_PASS / 2 + 6)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    push_target_group();
                    wait_taken();
                    items += GROUP_SAMPLES;
                end else if (pick < 85) begin
                    // stray point write, may leave the table unsorted
                    push_point($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, CODE_MAX),
                               rand_temp());
                    items++;
                end else begin
                    push_sample($urandom_range(0, CODE_MAX));
                    items++;
                end
            end
        end

        steady = 1'b0;
        wait_quiet();
        if (tracker.fails == 0 && tracker.expected_temps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
